[rtl/pcf_pkg.sv]
package pcf_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef enum logic [1:0] {
    CMD_OPEN,
    CMD_DATA,
    CMD_STRAY
  } cmd_kind_t;

  // One classified input word, as handed from the front to the back.
  typedef struct packed {
    cmd_kind_t   kind;
    logic        mis;
    logic        has_data;
    logic        close;
    logic [30:0] len;
    logic [31:0] ctype;
    logic [7:0]  dbyte;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_HEAD,
    BK_LEN,
    BK_TYPE,
    BK_DATA,
    BK_CRC,
    BK_STRAY
  } back_state_t;

  // Reflected CRC-32 table entry, worked bit by bit.
  function automatic logic [31:0] crc_table(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'b0, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    return (crc >> 8) ^ crc_table(crc[7:0] ^ b);
  endfunction

endpackage

[rtl/png_chunk_framer_crc32_core.sv]
// The first output word of an input word passes the command queue entry and then the output
//   register before the sink can take it.
// Throughput, while out_stall is low: one payload word per cycle; an opening word yields 9 to 13
//   output words and a closing payload word 5, one per cycle, set by the single output byte lane.
// A command queue of QUEUE_DEPTH entries absorbs header and CRC bursts on the input side.
// Reset (rst_n low, synchronous): queue empty, no chunk open, CRC all ones, out_valid low.
module png_chunk_framer_crc32_core #(
  parameter int QUEUE_DEPTH = pcf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_chunk_start,
  input  logic [31:0] in_chunk_type,
  input  logic [30:0] in_chunk_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_chunk_end,
  output logic        out_misplaced
);
  import pcf_pkg::*;

  logic q_full, q_valid, q_pop, push;
  cmd_t front_cmd, head_cmd;

  // Stall the input only while the queue is full; the front never waits otherwise.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Front: classify each word (open, payload, stray) and count payload down.
  pcf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .chunk_start  (in_chunk_start),
    .chunk_type   (in_chunk_type),
    .chunk_length (in_chunk_length),
    .data_byte    (in_data_byte),
    .cmd          (front_cmd)
  );

  // Queue: decouple classification from byte emission.
  pcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (front_cmd),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (head_cmd)
  );

  // Back: emit length, type, payload and CRC bytes; hold the running CRC.
  pcf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_valid),
    .head            (head_cmd),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_chunk_end   (out_chunk_end),
    .out_misplaced   (out_misplaced)
  );

endmodule

[rtl/pcf_front.sv]
module pcf_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic           chunk_start,
  input  logic [31:0]    chunk_type,
  input  logic [30:0]    chunk_length,
  input  logic [7:0]     data_byte,
  output pcf_pkg::cmd_t  cmd
);
  import pcf_pkg::*;

  logic        open_r, open_nxt;
  logic [30:0] rem_r, rem_nxt;

  // Classify the word against the open chunk and track the payload still due.
  always_comb begin
    cmd.ctype    = chunk_type;
    cmd.len      = chunk_length;
    cmd.dbyte    = data_byte;
    cmd.kind     = CMD_STRAY;
    cmd.mis      = 1'b1;
    cmd.has_data = 1'b0;
    cmd.close    = 1'b0;
    open_nxt     = open_r;
    rem_nxt      = rem_r;
    if (chunk_start) begin
      cmd.kind     = CMD_OPEN;
      cmd.mis      = open_r;
      cmd.has_data = (chunk_length != 31'd0);
      cmd.close    = (chunk_length[30:1] == 30'd0);
      open_nxt     = (chunk_length[30:1] != 30'd0);
      rem_nxt      = (chunk_length == 31'd0) ? 31'd0 : chunk_length - 31'd1;
    end else if (open_r) begin
      cmd.kind     = CMD_DATA;
      cmd.mis      = 1'b0;
      cmd.has_data = 1'b1;
      cmd.close    = (rem_r == 31'd1);
      open_nxt     = (rem_r != 31'd1);
      rem_nxt      = rem_r - 31'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rem_r  <= 31'd0;
    end else if (push) begin
      open_r <= open_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

[rtl/pcf_queue.sv]
module pcf_queue #(
  parameter int DEPTH = pcf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  pcf_pkg::cmd_t  wr_data,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output pcf_pkg::cmd_t  rd_data
);
  import pcf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (rd_en) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

[rtl/pcf_back.sv]
module pcf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  pcf_pkg::cmd_t  head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last_of_run,
  output logic           out_chunk_end,
  output logic           out_misplaced
);
  import pcf_pkg::*;

  back_state_t ph_r, ph_nxt, eff;
  logic [1:0]  idx_r, idx_nxt, sel;
  logic [31:0] crc_r, crc_nxt, crc_in, len32;
  logic        fire;
  logic [7:0]  byte_c;
  logic        last_c, end_c;

  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic        last_r, end_r, mis_r;

  assign fire  = head_valid && (!out_valid_r || !out_stall);
  assign sel   = 2'd3 - idx_r;
  assign len32 = {1'b0, head.len};

  always_comb begin
    eff = ph_r;
    if (ph_r == BK_HEAD) begin
      case (head.kind)
        CMD_OPEN: eff = BK_LEN;
        CMD_DATA: eff = BK_DATA;
        default:  eff = BK_STRAY;
      endcase
    end
  end

  // Next position within the head word.
  always_comb begin
    ph_nxt  = ph_r;
    idx_nxt = idx_r;
    if (fire) begin
      case (eff)
        BK_LEN: begin
          idx_nxt = idx_r + 2'd1;
          ph_nxt  = (idx_r == 2'd3) ? BK_TYPE : BK_LEN;
        end
        BK_TYPE: begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            ph_nxt = head.has_data ? BK_DATA : BK_CRC;
          end else begin
            ph_nxt = BK_TYPE;
          end
        end
        BK_DATA: begin
          idx_nxt = 2'd0;
          ph_nxt  = head.close ? BK_CRC : BK_HEAD;
        end
        BK_CRC: begin
          idx_nxt = idx_r + 2'd1;
          ph_nxt  = (idx_r == 2'd3) ? BK_HEAD : BK_CRC;
        end
        default: begin
          idx_nxt = 2'd0;
          ph_nxt  = BK_HEAD;
        end
      endcase
    end
  end

  // Byte, flags and CRC step for the current position.
  always_comb begin
    byte_c  = 8'd0;
    last_c  = 1'b0;
    end_c   = 1'b0;
    crc_in  = (idx_r == 2'd0) ? CRC_ONES : crc_r;
    crc_nxt = crc_r;
    case (eff)
      BK_LEN: begin
        byte_c = len32[{sel, 3'b000} +: 8];
      end
      BK_TYPE: begin
        byte_c  = head.ctype[{sel, 3'b000} +: 8];
        crc_nxt = crc_byte(crc_in, byte_c);
      end
      BK_DATA: begin
        byte_c  = head.dbyte;
        crc_nxt = crc_byte(crc_r, byte_c);
        last_c  = !head.close;
      end
      BK_CRC: begin
        byte_c  = ~crc_r[{sel, 3'b000} +: 8];
        last_c  = (idx_r == 2'd3);
        end_c   = (idx_r == 2'd3);
        crc_nxt = (idx_r == 2'd3) ? CRC_ONES : crc_r;
      end
      default: begin
        last_c = 1'b1;
      end
    endcase
  end

  assign pop = fire && last_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= BK_HEAD;
      idx_r       <= 2'd0;
      crc_r       <= CRC_ONES;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      idx_r       <= idx_nxt;
      if (fire) begin
        crc_r <= crc_nxt;
      end
      out_valid_r <= fire || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r <= byte_c;
      last_r <= last_c;
      end_r  <= end_c;
      mis_r  <= head.mis;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;
  assign out_chunk_end   = end_r;
  assign out_misplaced   = mis_r;

endmodule

[rtl/pcf_checker.sv]
module pcf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_of_run,
  input logic       out_chunk_end,
  input logic       out_misplaced
);

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last_of_run)
      && $stable(out_chunk_end) && $stable(out_misplaced))
    else $error("output word changed while stalled");

  // The last CRC byte always ends the run of its input word.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunk_end |-> out_last_of_run)
    else $error("chunk end without last of run");

  // Reset leaves nothing on the output.
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid straight after reset");

  // A valid word carries no unknown bits.
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_byte, out_last_of_run, out_chunk_end, out_misplaced}))
    else $error("unknown bits on a valid output word");

endmodule

bind png_chunk_framer_crc32_core pcf_checker u_pcf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run),
  .out_chunk_end   (out_chunk_end),
  .out_misplaced   (out_misplaced)
);
